@@ design/llma_pkg.sv @@
// Shared types and constants for the least-loaded machine assigner.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package llma_pkg;

  // Fixed field widths
  localparam int unsigned DUR_W  = 16;
  localparam int unsigned LOAD_W = 32;
  localparam int unsigned MID_W  = 4;
  localparam int unsigned CFG_W  = 5;

  localparam logic [CFG_W-1:0]  CFG_RESET = 5'd16;
  localparam logic [LOAD_W-1:0] LOAD_MAX  = {LOAD_W{1'b1}};

  // Controller states, one-hot
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_ROOT = 3'b010,
    S_SIFT = 3'b100
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic start;  // input transfer: latch duration, read root
    logic root;   // root read back: emit result, load carried entry
    logic step;   // one sift level: compare children, write one entry
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic sift_done;  // no child is strictly lighter than the carried entry
  } sts_t;

endpackage

@@ design/llma_ctrl.sv @@
// Controller state machine of the least-loaded machine assigner.
// Depends on llma_pkg for the state, command and status types.
`timescale 1ns / 1ps

module llma_ctrl import llma_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Sequence one task: accept, read root, sift down level by level
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_ROOT;
        end
      end
      S_ROOT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.root  = 1'b1;
          state_nxt = S_SIFT;
        end
      end
      S_SIFT: begin
        cmd.step = 1'b1;
        if (sts.sift_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the result until the downstream transfer
  always_comb begin
    out_valid_nxt = cmd.root | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ design/llma_dpath.sv @@
// Datapath of the least-loaded machine assigner: heap memory, valid bits,
// carried entry, child compare and result register. Depends on llma_pkg.
`timescale 1ns / 1ps

module llma_dpath import llma_pkg::*; #(
  parameter int unsigned MAX_MACHINES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cmd_t              cmd,
  output sts_t              sts,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_machines_in_use,
  input  logic [DUR_W-1:0]  in_task_duration,
  input  logic              in_start_new,
  output logic [MID_W-1:0]  out_machine_id,
  output logic [LOAD_W-1:0] out_load_after
);

  localparam int unsigned AW = $clog2(MAX_MACHINES);
  localparam int unsigned CW = $clog2(MAX_MACHINES + 1);
  localparam int unsigned XW = AW + 2;

  // Heap storage; an entry without its valid bit reads as id = index, load 0
  logic [AW-1:0]           mem_id [MAX_MACHINES];
  logic [LOAD_W-1:0]       mem_ld [MAX_MACHINES];
  logic [MAX_MACHINES-1:0] vld_r, vld_nxt;

  logic [CFG_W-1:0]  cfg_r;
  logic [DUR_W-1:0]  dur_r;
  logic [AW-1:0]     pos_r;
  logic [AW-1:0]     cur_id_r;
  logic [LOAD_W-1:0] cur_ld_r;
  logic [MID_W-1:0]  out_id_r;
  logic [LOAD_W-1:0] out_ld_r;

  logic [AW-1:0]     rd_a_addr_r, rd_b_addr_r;
  logic              rd_a_vld_r, rd_b_vld_r;
  logic [AW-1:0]     rd_a_id_r, rd_b_id_r;
  logic [LOAD_W-1:0] rd_a_ld_r, rd_b_ld_r;

  logic [31:0]       cfg_ext, live_ext;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     a_id, b_id, win_id, wr_id, rd_a_addr, rd_b_addr;
  logic [LOAD_W-1:0] a_ld, b_ld, lmin, win_ld, wr_ld, sat_sum;
  logic [LOAD_W:0]   sum;
  logic [XW-1:0]     lc, rc, cnt_x, nlc, nrc;
  logic              l_ok, r_ok, clr;
  logic [AW-1:0]     win_addr;
  logic [31:0]       root_id_ext;

  function automatic logic [AW-1:0] mem_addr(input logic [XW-1:0] x);
    mem_addr = (x < XW'(MAX_MACHINES)) ? x[AW-1:0] : '0;
  endfunction

  // Live machine count: zero acts as one, clamp to the heap depth
  always_comb begin
    cfg_ext = 32'(cfg_r);
    if (cfg_ext == 32'd0) begin
      live_ext = 32'd1;
    end else if (cfg_ext > 32'(MAX_MACHINES)) begin
      live_ext = 32'(MAX_MACHINES);
    end else begin
      live_ext = cfg_ext;
    end
    cnt   = live_ext[CW-1:0];
    cnt_x = XW'(cnt);
  end

  // Resolve read data against valid bits
  always_comb begin
    a_id = rd_a_vld_r ? rd_a_id_r : rd_a_addr_r;
    a_ld = rd_a_vld_r ? rd_a_ld_r : '0;
    b_id = rd_b_vld_r ? rd_b_id_r : rd_b_addr_r;
    b_ld = rd_b_vld_r ? rd_b_ld_r : '0;
  end

  // Saturating add of the duration onto the root load
  always_comb begin
    sum         = {1'b0, a_ld} + (LOAD_W + 1)'(dur_r);
    sat_sum     = sum[LOAD_W] ? LOAD_MAX : sum[LOAD_W-1:0];
    root_id_ext = 32'(a_id);
  end

  // One sift level: left wins on strictly less, right on strictly less than winner
  always_comb begin
    lc       = (XW'(pos_r) << 1) + XW'(1);
    rc       = lc + XW'(1);
    l_ok     = (lc < cnt_x) && (a_ld < cur_ld_r);
    lmin     = l_ok ? a_ld : cur_ld_r;
    r_ok     = (rc < cnt_x) && (b_ld < lmin);
    win_addr = r_ok ? rc[AW-1:0] : lc[AW-1:0];
    win_id   = r_ok ? b_id : a_id;
    win_ld   = r_ok ? b_ld : a_ld;
    nlc      = (XW'(win_addr) << 1) + XW'(1);
    nrc      = nlc + XW'(1);
    sts.sift_done = !(l_ok || r_ok);
    wr_id    = sts.sift_done ? cur_id_r : win_id;
    wr_ld    = sts.sift_done ? cur_ld_r : win_ld;
  end

  // Read addresses: root on start and while idle, children of the next position on root and step
  always_comb begin
    if (cmd.root) begin
      rd_a_addr = mem_addr(XW'(1));
      rd_b_addr = mem_addr(XW'(2));
    end else if (cmd.step) begin
      rd_a_addr = mem_addr(nlc);
      rd_b_addr = mem_addr(nrc);
    end else begin
      rd_a_addr = '0;
      rd_b_addr = '0;
    end
  end

  assign clr = cmd.start & in_start_new;

  // Drop all entries on a fresh schedule, mark entries as they are written
  always_comb begin
    vld_nxt = vld_r;
    if (clr) begin
      vld_nxt = '0;
    end else if (cmd.step) begin
      vld_nxt[pos_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      cfg_r <= CFG_RESET;
    end else begin
      vld_r <= vld_nxt;
      if (cfg_we) begin
        cfg_r <= cfg_machines_in_use;
      end
    end
  end

  // Heap memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      mem_id[pos_r] <= wr_id;
      mem_ld[pos_r] <= wr_ld;
    end
    rd_a_addr_r <= rd_a_addr;
    rd_b_addr_r <= rd_b_addr;
    rd_a_id_r   <= mem_id[rd_a_addr];
    rd_a_ld_r   <= mem_ld[rd_a_addr];
    rd_b_id_r   <= mem_id[rd_b_addr];
    rd_b_ld_r   <= mem_ld[rd_b_addr];
    rd_a_vld_r  <= vld_r[rd_a_addr] & ~clr;
    rd_b_vld_r  <= vld_r[rd_b_addr] & ~clr;
  end

  // Carried entry, position and result register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dur_r <= in_task_duration;
    end
    if (cmd.root) begin
      out_id_r <= root_id_ext[MID_W-1:0];
      out_ld_r <= sat_sum;
      cur_id_r <= a_id;
      cur_ld_r <= sat_sum;
      pos_r    <= '0;
    end else if (cmd.step && !sts.sift_done) begin
      pos_r <= win_addr;
    end
  end

  assign out_machine_id = out_id_r;
  assign out_load_after = out_ld_r;

endmodule

@@ design/least_loaded_machine_assigner.sv @@
// Top level of the least-loaded machine assigner (list scheduling on a min-heap).
// Instantiates llma_ctrl and llma_dpath; depends on llma_pkg.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  in_     | input     | in_valid / in_stall   | in_task_duration[15:0], in_start_new
//  out_    | output    | out_valid / out_stall | out_machine_id[3:0], out_load_after[31:0]
//  cfg_    | input     | cfg_valid / cfg_ready | cfg_machines_in_use[4:0]
//
// One task at a time: the input stalls after a transfer until the root entry
// has moved down its heap levels, at most floor(log2(count)) of them. One
// sift level per cycle, set by the two-read, one-write heap memory. The result
// is registered from the root read that follows the transfer, and the next
// task can enter while it waits; a stalled result holds the block in its root
// state. Synchronous reset leaves ids 0..N-1 with zero loads and 16 machines
// in use.
`timescale 1ns / 1ps

module least_loaded_machine_assigner import llma_pkg::*; #(
  parameter int unsigned MAX_MACHINES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [DUR_W-1:0]  in_task_duration,
  input  logic              in_start_new,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [MID_W-1:0]  out_machine_id,
  output logic [LOAD_W-1:0] out_load_after,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_machines_in_use
);

  cmd_t cmd;
  sts_t sts;

  // Register writes must arrive only while idle; the block itself does not enforce it
  assign cfg_ready = 1'b1;

  llma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  llma_dpath #(
    .MAX_MACHINES (MAX_MACHINES)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_valid & cfg_ready),
    .cfg_machines_in_use (cfg_machines_in_use),
    .in_task_duration    (in_task_duration),
    .in_start_new        (in_start_new),
    .out_machine_id      (out_machine_id),
    .out_load_after      (out_load_after)
  );

endmodule

@@ design/llma_checker.sv @@
// Port-level checker for the least-loaded machine assigner, bound to the top.
// Depends on llma_pkg for field widths.
`timescale 1ns / 1ps

module llma_checker import llma_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic [DUR_W-1:0]  in_task_duration,
  input logic              in_start_new,
  input logic              out_valid,
  input logic              out_stall,
  input logic [MID_W-1:0]  out_machine_id,
  input logic [LOAD_W-1:0] out_load_after
);

  // Stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_machine_id)
                               && $stable(out_load_after))
    else $error("stalled result changed");

  // After a task transfer, the input is stalled
  a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after a transfer");

  // A fresh schedule hands its first task to machine 0 with load = duration
  a_fresh_first: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_start_new && !out_valid |-> ##2
      out_valid && (out_machine_id == '0)
      && (out_load_after == LOAD_W'($past(in_task_duration, 2))))
    else $error("fresh schedule result wrong");

  // A new result only appears while a task is in flight
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a task in flight");

  // Reset leaves the block open and empty
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("block not idle after reset");

endmodule

bind least_loaded_machine_assigner llma_checker u_llma_checker (.*);
